/* design/c3z_pkg.sv */
// Shared types and constants of the 3x3 zero-padded streaming convolution.
// No dependencies; used by c3z_mac and conv3x3_zero_padded_stream.
`default_nettype none

package c3z_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned KROW_W  = 3 * COEF_W;
  localparam int unsigned PROD_W  = PIX_W + COEF_W;
  localparam int unsigned RSUM_W  = PROD_W + 2;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned ROWS_W  = 12;
  localparam int unsigned COLS_W  = 6;
  localparam int unsigned CFG_W   = KROW_W;
  localparam int unsigned CIDX_W  = 3;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_FRAME_ROWS    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_COLS    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CIDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  typedef logic [PIX_W-1:0]              tap_t;
  typedef logic [2:0][2:0][PIX_W-1:0]    window_t;  // [row][col], col 2 newest
  typedef logic [2:0][KROW_W-1:0]        kernel_t;  // [row], col c in bits 16c+15..16c

  typedef struct packed {
    logic run_end;
    logic frame_end;
  } tag_t;

endpackage

`default_nettype wire

/* design/c3z_mac.sv */
// Three-stage multiply-accumulate pipeline for one 3x3 window: products, row sums,
// then the output register. Depends on c3z_pkg for window, kernel and tag types.
`default_nettype none

module c3z_mac (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              launch,
  input  wire c3z_pkg::window_t  window,
  input  wire c3z_pkg::kernel_t  kernel,
  input  wire c3z_pkg::tag_t     tag,
  input  wire logic              out_stall,
  output logic                   advance,
  output logic                   out_valid,
  output logic signed [c3z_pkg::SUM_W-1:0] filtered,
  output c3z_pkg::tag_t          out_tag
);

  logic signed [c3z_pkg::PROD_W-1:0] prod [3][3];
  logic                              s1_valid;
  c3z_pkg::tag_t                     s1_tag;
  logic signed [c3z_pkg::RSUM_W-1:0] rsum [3];
  logic                              s2_valid;
  c3z_pkg::tag_t                     s2_tag;

  // The whole pipeline moves together; it holds while the output word is stalled.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= launch;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(window[r][c]) *
                        $signed(kernel[r][c*c3z_pkg::COEF_W +: c3z_pkg::COEF_W]);
        end
        rsum[r] <= c3z_pkg::RSUM_W'(prod[r][0]) + c3z_pkg::RSUM_W'(prod[r][1])
                 + c3z_pkg::RSUM_W'(prod[r][2]);
      end
      s1_tag   <= tag;
      s2_tag   <= s1_tag;
      filtered <= c3z_pkg::SUM_W'(rsum[0]) + c3z_pkg::SUM_W'(rsum[1])
                + c3z_pkg::SUM_W'(rsum[2]);
      out_tag  <= s2_tag;
    end
  end

endmodule

`default_nettype wire

/* design/conv3x3_zero_padded_stream.sv */
// Streaming 3x3 convolution, same-size output with zero padding.
// A result passes the product and row-sum registers before it enters the output register.
// Pixel words are taken one at a time: in_stall is high outside S_IDLE, so the line
// memory read, the update step and any right-border or bottom-row drain steps for one
// pixel finish before the next pixel word is accepted.
// Reset (rst, synchronous): registers to rows 1, cols 1, kernel 0, position 0.
`default_nettype none

module conv3x3_zero_padded_stream #(
  parameter int unsigned MAX_COLS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  // configuration write port
  input  wire logic                              cfg_write,
  input  wire logic [c3z_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [c3z_pkg::CFG_W-1:0]         cfg_data,
  // pixel words in
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [c3z_pkg::PIX_W-1:0]  pixel,
  // result words out
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [c3z_pkg::SUM_W-1:0]       filtered,
  output logic                                   run_end,
  output logic                                   frame_end
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic [c3z_pkg::COLS_W-1:0] COLS_CAP = c3z_pkg::COLS_W'(MAX_COLS);

  typedef enum logic [2:0] {
    S_IDLE,    // wait for a pixel word
    S_PIX,     // line data back: shift window, write lines, emit centre result
    S_BORDER,  // right-border result of the row
    S_DRAIN,   // bottom padding row, one column per cycle while the pipeline advances
    S_FINAL    // bottom-right corner result, closes the frame
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [c3z_pkg::ROWS_W-1:0] cfg_rows;
  logic [c3z_pkg::COLS_W-1:0] cfg_cols;
  c3z_pkg::kernel_t           kernel;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rows <= c3z_pkg::ROWS_W'(1);
      cfg_cols <= c3z_pkg::COLS_W'(1);
      kernel   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        c3z_pkg::REG_FRAME_ROWS:    cfg_rows  <= cfg_data[c3z_pkg::ROWS_W-1:0];
        c3z_pkg::REG_FRAME_COLS:    cfg_cols  <= cfg_data[c3z_pkg::COLS_W-1:0];
        c3z_pkg::REG_KERNEL_TOP:    kernel[0] <= cfg_data;
        c3z_pkg::REG_KERNEL_MIDDLE: kernel[1] <= cfg_data;
        c3z_pkg::REG_KERNEL_BOTTOM: kernel[2] <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Effective frame size: zero counts as one, columns saturate at the line width.
  logic [c3z_pkg::ROWS_W-1:0] rows_eff;
  logic [c3z_pkg::COLS_W-1:0] cols_eff;

  always_comb begin
    rows_eff = (cfg_rows == '0) ? c3z_pkg::ROWS_W'(1) : cfg_rows;
    if (cfg_cols == '0) begin
      cols_eff = c3z_pkg::COLS_W'(1);
    end else if (cfg_cols > COLS_CAP) begin
      cols_eff = COLS_CAP;
    end else begin
      cols_eff = cfg_cols;
    end
  end

  // ---------------------------------------------------------------------------
  // Position, window and control state
  // ---------------------------------------------------------------------------
  state_t                     state;
  logic [c3z_pkg::ROWS_W-1:0] row;
  logic [c3z_pkg::COLS_W-1:0] col;      // pixel column, reused as drain column
  logic [c3z_pkg::COLS_W-1:0] col_inc;
  c3z_pkg::tap_t              pix_q;
  c3z_pkg::window_t           window;
  c3z_pkg::window_t           window_next;
  logic [MAX_COLS-1:0]        line_ok;  // entry written since frame start

  // ---------------------------------------------------------------------------
  // Line memory: one entry per column, {upper row, lower row}
  // ---------------------------------------------------------------------------
  logic [2*c3z_pkg::PIX_W-1:0] line_mem [MAX_COLS];
  logic [2*c3z_pkg::PIX_W-1:0] rd_q;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [2*c3z_pkg::PIX_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= line_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Step decode
  // ---------------------------------------------------------------------------
  logic                       adv;
  logic                       accept;
  logic                       last_col;
  logic                       last_row;
  logic                       wrap;
  logic                       start_frame;
  logic [c3z_pkg::COLS_W-1:0] col_start;
  logic [c3z_pkg::ROWS_W-1:0] row_start;
  c3z_pkg::tap_t              upper_eff;
  c3z_pkg::tap_t              lower_eff;
  c3z_pkg::tap_t              new_top;
  c3z_pkg::tap_t              new_mid;
  c3z_pkg::tap_t              new_bot;
  logic                       win_clear;
  logic                       emit;
  c3z_pkg::tag_t              tag;
  c3z_pkg::tag_t              out_tag;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign col_inc  = col + c3z_pkg::COLS_W'(1);
  assign last_col = (col == cols_eff - c3z_pkg::COLS_W'(1));
  assign last_row = (row == rows_eff - c3z_pkg::ROWS_W'(1));

  // A position left outside a shrunk frame starts a new frame.
  assign wrap        = (col >= cols_eff) || (row >= rows_eff);
  assign col_start   = wrap ? '0 : col;
  assign row_start   = wrap ? '0 : row;
  assign start_frame = (col_start == '0) && (row_start == '0);

  // Entries not written this frame read as zero.
  assign upper_eff = line_ok[col[AW-1:0]] ? rd_q[2*c3z_pkg::PIX_W-1:c3z_pkg::PIX_W] : '0;
  assign lower_eff = line_ok[col[AW-1:0]] ? rd_q[c3z_pkg::PIX_W-1:0] : '0;

  always_comb begin
    new_top   = '0;
    new_mid   = '0;
    new_bot   = '0;
    win_clear = 1'b0;
    emit      = 1'b0;
    tag       = '0;
    unique case (state)
      S_PIX: begin
        new_top       = upper_eff;
        new_mid       = lower_eff;
        new_bot       = pix_q;
        win_clear     = (col == '0);
        emit          = (row != '0) && (col != '0);
        // a row's last pixel always has a border or drain result after this one
        tag.run_end   = !last_col;
      end
      S_BORDER: begin
        emit          = (row != '0);
        tag.run_end   = !last_row;
      end
      S_DRAIN: begin
        new_top       = upper_eff;
        new_mid       = lower_eff;
        emit          = (col != '0);
      end
      S_FINAL: begin
        emit          = 1'b1;
        tag.run_end   = 1'b1;
        tag.frame_end = 1'b1;
      end
      default: ;
    endcase
  end

  // Shift the window left and insert the new column on the right.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r][0] = win_clear ? '0 : window[r][1];
      window_next[r][1] = win_clear ? '0 : window[r][2];
    end
    window_next[0][2] = new_top;
    window_next[1][2] = new_mid;
    window_next[2][2] = new_bot;
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = col_start[AW-1:0];
    unique case (state)
      S_IDLE: begin
        rd_en   = in_valid;
        rd_addr = col_start[AW-1:0];
      end
      S_BORDER: begin
        rd_en   = adv && last_row;
        rd_addr = '0;
      end
      S_DRAIN: begin
        rd_en   = adv && !last_col;
        rd_addr = col_inc[AW-1:0];
      end
      default: ;
    endcase
  end

  // Roll the lower row up and store the new pixel.
  assign wr_en   = (state == S_PIX) && adv;
  assign wr_addr = col[AW-1:0];
  assign wr_data = {lower_eff, pix_q};

  // ---------------------------------------------------------------------------
  // Sequencer: every step past IDLE waits for the result pipeline to advance
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row     <= '0;
      col     <= '0;
      line_ok <= '0;
      window  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pix_q <= pixel;
            row   <= row_start;
            col   <= col_start;
            if (start_frame) begin
              line_ok <= '0;
            end
            state <= S_PIX;
          end
        end
        S_PIX: begin
          if (adv) begin
            window                <= window_next;
            line_ok[col[AW-1:0]] <= 1'b1;
            if (last_col) begin
              state <= S_BORDER;
            end else begin
              col   <= col_inc;
              state <= S_IDLE;
            end
          end
        end
        S_BORDER: begin
          if (adv) begin
            col <= '0;
            if (last_row) begin
              // the drain starts from a clear window
              window <= '0;
              state  <= S_DRAIN;
            end else begin
              window <= window_next;
              row    <= row + c3z_pkg::ROWS_W'(1);
              state  <= S_IDLE;
            end
          end
        end
        S_DRAIN: begin
          if (adv) begin
            window <= window_next;
            if (last_col) begin
              state <= S_FINAL;
            end else begin
              col <= col_inc;
            end
          end
        end
        S_FINAL: begin
          if (adv) begin
            window <= window_next;
            row    <= '0;
            col    <= '0;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate pipeline and output register
  // ---------------------------------------------------------------------------
  c3z_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .launch    (emit && adv),
    .window    (window_next),
    .kernel    (kernel),
    .tag       (tag),
    .out_stall (out_stall),
    .advance   (adv),
    .out_valid (out_valid),
    .filtered  (filtered),
    .out_tag   (out_tag)
  );

  assign run_end   = out_tag.run_end;
  assign frame_end = out_tag.frame_end;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_frame_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_end)
    else $error("frame_end without run_end");

  a_accept_to_pix: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PIX)
    else $error("accepted pixel did not enter the line update step");

  a_drain_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> $past(state == S_BORDER || state == S_DRAIN))
    else $error("drain entered without a right-border step");

endmodule

`default_nettype wire
